@@ design/dsp2m_pkg.sv @@
// shared types, widths and helper functions for the two-motor differential speed pid
// no dependencies
package dsp2m_pkg;

  // widths of the stored error and drive accumulator
  localparam int ERR_W     = 24;
  localparam int ACC_W     = 32;
  localparam int SUM_W     = ((ACC_W > ERR_W + 18) ? ACC_W : ERR_W + 18) + 3;

  // shared multiplier operand and product widths
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;

  // target path widths
  localparam int COMMON_W  = 29;
  localparam int FACT_W    = 31;
  localparam int FULL_W    = 62;
  localparam int TGT_W     = 42;
  localparam int DIFF_W    = 43;
  localparam int DUTY_W    = 15;
  localparam int DIV_STEPS = 8;

  localparam logic [DUTY_W-1:0] DUTY_MAX  = 15'd23040;
  localparam logic [ACC_W-1:0]  ACC_RESET = ACC_W'(10 * 65536);

  // register indexes of the configuration port
  localparam logic [2:0] REG_BASE_SPEED  = 3'd0;
  localparam logic [2:0] REG_FLOOR_SPEED = 3'd1;
  localparam logic [2:0] REG_FLOOR_EN    = 3'd2;
  localparam logic [2:0] REG_SLOW_GAIN   = 3'd3;
  localparam logic [2:0] REG_DIFF_GAIN   = 3'd4;
  localparam logic [2:0] REG_DIFF_BASE   = 3'd5;
  localparam logic [2:0] REG_LEFT_GAINS  = 3'd6;
  localparam logic [2:0] REG_RIGHT_GAINS = 3'd7;

  // configuration register set
  typedef struct packed {
    logic [7:0]  base_speed;
    logic [7:0]  floor_speed;
    logic        floor_enable;
    logic [15:0] slowdown_gain;
    logic [15:0] diff_gain;
    logic [15:0] diff_base;
    logic [47:0] left_gains;
    logic [47:0] right_gains;
  } cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic              neg;
    logic [15:0]       kin;
    logic signed [15:0] count_l;
    logic signed [15:0] count_r;
  } item_t;

  // saturate an error difference to the error width
  function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [DIFF_W-1:0] x);
    logic signed [DIFF_W-1:0] hi;
    logic signed [DIFF_W-1:0] lo;
    hi = {{(DIFF_W-ERR_W+1){1'b0}}, {(ERR_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) return hi[ERR_W-1:0];
    else if (x < lo) return lo[ERR_W-1:0];
    else return x[ERR_W-1:0];
  endfunction

  // saturate the pid sum to the accumulator width
  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    lo = ~hi;
    if (x > hi) return hi[ACC_W-1:0];
    else if (x < lo) return lo[ACC_W-1:0];
    else return x[ACC_W-1:0];
  endfunction

endpackage

@@ design/dsp2m_front.sv @@
// front end: takes input items, finds the inner wheel side and |curvature|
// depends on dsp2m_pkg
module dsp2m_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [47:0]          in_data,
  output logic                 push,
  output dsp2m_pkg::item_t     push_item,
  input  logic                 q_full
);
  import dsp2m_pkg::*;

  logic  fr_valid_r, fr_valid_nxt;
  item_t fr_item_r;
  logic signed [15:0] curv;

  assign curv      = in_data[15:0];
  assign push      = fr_valid_r && !q_full;
  assign push_item = fr_item_r;
  assign in_ready  = !fr_valid_r || !q_full;

  // holding register valid
  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (in_valid && in_ready) fr_valid_nxt = 1'b1;
    else if (push) fr_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fr_valid_r <= 1'b0;
    else fr_valid_r <= fr_valid_nxt;
  end

  // classify: sign picks the inner wheel, magnitude drives the slowdown
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_item_r.neg     <= curv[15];
      fr_item_r.kin     <= curv[15] ? 16'(-curv) : 16'(curv);
      fr_item_r.count_l <= in_data[31:16];
      fr_item_r.count_r <= in_data[47:32];
    end
  end

endmodule

@@ design/dsp2m_queue.sv @@
// two-entry item queue between front and back
// depends on dsp2m_pkg
module dsp2m_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  dsp2m_pkg::item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output dsp2m_pkg::item_t pop_item
);
  import dsp2m_pkg::*;

  item_t      ent_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_item  = ent_r[rd_r];

  // pointers and fill count
  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) ent_r[wr_r] <= push_item;
  end

endmodule

@@ design/dsp2m_back.sv @@
// back end: target computation and per-motor incremental pid over a shared multiplier
// depends on dsp2m_pkg
module dsp2m_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dsp2m_pkg::cfg_t      cfg,
  input  logic                 q_not_empty,
  input  dsp2m_pkg::item_t     q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [63:0]          out_data
);
  import dsp2m_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_SLOW   = 15'b000000000000010,
    S_BASE   = 15'b000000000000100,
    S_COMMON = 15'b000000000001000,
    S_DIV0   = 15'b000000000010000,
    S_DIV    = 15'b000000000100000,
    S_FLO    = 15'b000000001000000,
    S_FHI    = 15'b000000010000000,
    S_TGT    = 15'b000000100000000,
    S_ERR    = 15'b000001000000000,
    S_PP     = 15'b000010000000000,
    S_PI     = 15'b000100000000000,
    S_PD     = 15'b001000000000000,
    S_ACC    = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;
  item_t  item_r;

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  // target path
  logic signed [32:0]          diffv;
  logic signed [COMMON_W-1:0]  common_raw, common_r;
  logic [31:0]                 x_r, q_r;
  logic [2:0]                  rem_r, div_cnt_r;
  logic [6:0]                  dv;
  logic [13:0]                 dv_mul;
  logic [3:0]                  qd;
  logic [6:0]                  qd5;
  logic [33:0]                 m7;
  logic signed [32:0]          fact_full;
  logic signed [FACT_W-1:0]    factor;
  logic signed [PROD_W-1:0]    plo_r;
  logic signed [FULL_W-1:0]    full;
  logic signed [TGT_W-1:0]     inner, common_t, tgt_l_r, tgt_r_r;

  // pid state and working registers
  logic                        mot_r;
  logic signed [ERR_W-1:0]     len_r, lep_r, ren_r, rep_r;
  logic signed [ACC_W-1:0]     lacc_r, racc_r;
  logic signed [ERR_W-1:0]     e_r, e1, e2, e_n;
  logic signed [ERR_W:0]       de1_r;
  logic signed [ERR_W+1:0]     dd_r;
  logic signed [SUM_W-1:0]     sum_r, sum_fin;
  logic signed [TGT_W-1:0]     tgt_sel;
  logic signed [15:0]          cnt_sel;
  logic [47:0]                 gains_sel;
  logic signed [ACC_W-1:0]     acc_sel, acc_new;
  logic signed [DIFF_W-1:0]    diff;
  logic [ACC_W-1:0]            mag;
  logic [ACC_W-10:0]           mag_sh;
  logic [DUTY_W-1:0]           duty;
  logic [DUTY_W-1:0]           lf_r, lr_r;
  logic                        out_valid_r, out_valid_nxt;
  logic [63:0]                 out_data_r;

  assign q_pop     = (state_r == S_IDLE) && q_not_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // target arithmetic
  assign diffv      = 33'sd1048576 - $signed({1'b0, prod_r[31:0]});
  assign common_raw = prod_r[40:12];
  assign m7         = {prod_r[30:0], 3'b000} - {3'b000, prod_r[30:0]};
  assign dv         = {rem_r, x_r[31:28]};
  assign dv_mul     = 14'(dv) * 14'd205;
  assign qd         = dv_mul[13:10];
  assign qd5        = 7'(qd) * 7'd5;
  assign fact_full  = $signed({5'b0, cfg.diff_base, 12'b0}) - $signed({1'b0, q_r});
  assign factor     = fact_full[FACT_W-1:0];
  assign full       = (FULL_W'(prod_r) <<< 16) + FULL_W'(plo_r);
  assign inner      = full[FULL_W-1:20];
  assign common_t   = TGT_W'(common_r);

  // per-motor selection
  assign tgt_sel   = mot_r ? tgt_r_r : tgt_l_r;
  assign cnt_sel   = mot_r ? item_r.count_r : item_r.count_l;
  assign gains_sel = mot_r ? cfg.right_gains : cfg.left_gains;
  assign e1        = mot_r ? ren_r : len_r;
  assign e2        = mot_r ? rep_r : lep_r;
  assign acc_sel   = mot_r ? racc_r : lacc_r;

  // error, accumulator and duty
  assign diff    = DIFF_W'(tgt_sel) - (DIFF_W'(cnt_sel) <<< 8);
  assign e_n     = sat_err(diff);
  assign sum_fin = sum_r + SUM_W'(prod_r);
  assign acc_new = sat_acc(sum_fin);
  assign mag     = acc_new[ACC_W-1] ? ACC_W'(-acc_new) : ACC_W'(acc_new);
  assign mag_sh  = mag[ACC_W-1:9];
  assign duty    = (mag_sh > (ACC_W-9)'(DUTY_MAX)) ? DUTY_MAX : mag_sh[DUTY_W-1:0];

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_SLOW: begin
        mul_a = MUL_A_W'({1'b0, item_r.kin});
        mul_b = {1'b0, cfg.slowdown_gain};
      end
      S_BASE: begin
        mul_a = MUL_A_W'(diffv);
        mul_b = {9'b0, cfg.base_speed};
      end
      S_COMMON: begin
        mul_a = MUL_A_W'({1'b0, item_r.kin});
        mul_b = {1'b0, cfg.diff_gain};
      end
      S_FLO: begin
        mul_a = MUL_A_W'(common_r);
        mul_b = {1'b0, factor[15:0]};
      end
      S_FHI: begin
        // upper factor half is signed
        mul_a = MUL_A_W'(common_r);
        mul_b = MUL_B_W'($signed(factor[FACT_W-1:16]));
      end
      S_PP: begin
        mul_a = MUL_A_W'(de1_r);
        mul_b = {1'b0, gains_sel[47:32]};
      end
      S_PI: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = {1'b0, gains_sel[31:16]};
      end
      S_PD: begin
        mul_a = MUL_A_W'(dd_r);
        mul_b = {1'b0, gains_sel[15:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) prod_r <= mul_a * mul_b;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE:   if (q_not_empty) state_nxt = S_SLOW;
      S_SLOW:   state_nxt = S_BASE;
      S_BASE:   state_nxt = S_COMMON;
      S_COMMON: state_nxt = S_DIV0;
      S_DIV0:   state_nxt = S_DIV;
      S_DIV:    if (div_cnt_r == 3'(DIV_STEPS - 1)) state_nxt = S_FLO;
      S_FLO:    state_nxt = S_FHI;
      S_FHI:    state_nxt = S_TGT;
      S_TGT:    state_nxt = S_ERR;
      S_ERR:    state_nxt = S_PP;
      S_PP:     state_nxt = S_PI;
      S_PI:     state_nxt = S_PD;
      S_PD:     state_nxt = S_ACC;
      S_ACC:    state_nxt = mot_r ? S_OUT : S_ERR;
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pid history and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      lep_r  <= '0;
      ren_r  <= '0;
      rep_r  <= '0;
      lacc_r <= ACC_RESET;
      racc_r <= ACC_RESET;
    end else if (state_r == S_ACC) begin
      if (mot_r) begin
        ren_r  <= e_r;
        rep_r  <= ren_r;
        racc_r <= acc_new;
      end else begin
        len_r  <= e_r;
        lep_r  <= len_r;
        lacc_r <= acc_new;
      end
    end
  end

  // right motor duty from its stored accumulator
  function automatic logic [DUTY_W-1:0] duty_r_hold();
    logic [ACC_W-1:0]  m;
    logic [ACC_W-10:0] s;
    m = racc_r[ACC_W-1] ? ACC_W'(-racc_r) : ACC_W'(racc_r);
    s = m[ACC_W-1:9];
    return (s > (ACC_W-9)'(DUTY_MAX)) ? DUTY_MAX : s[DUTY_W-1:0];
  endfunction

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        item_r <= q_item;
        mot_r  <= 1'b0;
      end
      S_COMMON: begin
        // floor the common target when enabled
        if (cfg.floor_enable && (common_raw < $signed({13'b0, cfg.floor_speed, 8'b0})))
          common_r <= $signed({13'b0, cfg.floor_speed, 8'b0});
        else
          common_r <= common_raw;
      end
      S_DIV0: begin
        // |term| = (kin * diff_gain * 7 / 4) / 5, quotient built one nibble a step
        x_r       <= m7[33:2];
        rem_r     <= 3'd0;
        q_r       <= '0;
        div_cnt_r <= 3'd0;
      end
      S_DIV: begin
        x_r       <= {x_r[27:0], 4'b0};
        rem_r     <= 3'(dv - qd5);
        q_r       <= {q_r[27:0], qd};
        div_cnt_r <= div_cnt_r + 3'd1;
      end
      S_FHI: plo_r <= prod_r;
      S_TGT: begin
        // inner wheel trimmed, both clipped at zero
        if (item_r.neg) begin
          tgt_l_r <= common_t[TGT_W-1] ? '0 : common_t;
          tgt_r_r <= inner[TGT_W-1] ? '0 : inner;
        end else begin
          tgt_l_r <= inner[TGT_W-1] ? '0 : inner;
          tgt_r_r <= common_t[TGT_W-1] ? '0 : common_t;
        end
      end
      S_ERR: begin
        e_r   <= e_n;
        de1_r <= (ERR_W+1)'(e_n) - (ERR_W+1)'(e1);
        dd_r  <= (ERR_W+2)'(e_n) - ((ERR_W+2)'(e1) <<< 1) + (ERR_W+2)'(e2);
      end
      S_PI: sum_r <= SUM_W'(acc_sel) + SUM_W'(prod_r);
      S_PD: sum_r <= sum_fin;
      S_ACC: begin
        mot_r <= 1'b1;
        if (!mot_r) begin
          lf_r <= (acc_new > 0) ? duty : '0;
          lr_r <= (acc_new > 0) ? '0 : duty;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready)
          out_data_r <= {4'b0, ((acc_sel > 0) ? '0 : duty_r_hold()),
                         ((acc_sel > 0) ? duty_r_hold() : '0), lr_r, lf_r};
      end
      default: ;
    endcase
  end

endmodule

@@ design/differential_speed_pid_two_motor.sv @@
// top level of the two-motor differential speed pid: configuration registers,
// front end, item queue and back end. The back end works on one item at a time,
// sequencing all products through one shared 34x17 multiplier and an 8-step
// divide by five, and takes no new item until the last result has been offered.
// Synchronous active-low reset restores register defaults, zero errors and
// accumulators at 10.0; front register and queue hold up to three items ahead of the back.
module differential_speed_pid_two_motor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // curvature, count_left, count_right
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // duty_left_fwd, duty_left_rev, duty_right_fwd,
                                  // duty_right_rev, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);
  import dsp2m_pkg::*;

  cfg_t  cfg_r;
  logic  push, q_full, q_pop, q_not_empty;
  item_t push_item, pop_item;

  // configuration register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_speed    <= 8'd20;
      cfg_r.floor_speed   <= 8'd18;
      cfg_r.floor_enable  <= 1'b1;
      cfg_r.slowdown_gain <= 16'd256;
      cfg_r.diff_gain     <= 16'd113;
      cfg_r.diff_base     <= 16'd256;
      cfg_r.left_gains    <= 48'd671088640;
      cfg_r.right_gains   <= 48'd671088640;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BASE_SPEED:  cfg_r.base_speed    <= cfg_wdata[7:0];
        REG_FLOOR_SPEED: cfg_r.floor_speed   <= cfg_wdata[7:0];
        REG_FLOOR_EN:    cfg_r.floor_enable  <= cfg_wdata[0];
        REG_SLOW_GAIN:   cfg_r.slowdown_gain <= cfg_wdata[15:0];
        REG_DIFF_GAIN:   cfg_r.diff_gain     <= cfg_wdata[15:0];
        REG_DIFF_BASE:   cfg_r.diff_base     <= cfg_wdata[15:0];
        REG_LEFT_GAINS:  cfg_r.left_gains    <= cfg_wdata;
        REG_RIGHT_GAINS: cfg_r.right_gains   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dsp2m_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (in_tdata),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  dsp2m_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  dsp2m_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata)
  );

endmodule

@@ design/dsp2m_checker.sv @@
// port-level checks for the two-motor differential speed pid, bound to the top level
// depends on differential_speed_pid_two_motor ports only
module dsp2m_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // only one drive direction per motor
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:0] == 15'd0 || out_tdata[29:15] == 15'd0) &&
                   (out_tdata[44:30] == 15'd0 || out_tdata[59:45] == 15'd0))
    else $error("forward and reverse drive both set");

  // duties clamped and pad bits clear
  a_duty_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:0] <= 15'd23040 && out_tdata[29:15] <= 15'd23040 &&
                   out_tdata[44:30] <= 15'd23040 && out_tdata[59:45] <= 15'd23040 &&
                   out_tdata[63:60] == 4'd0)
    else $error("duty beyond limit");

endmodule

bind differential_speed_pid_two_motor dsp2m_checker u_dsp2m_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
